### hdl/prwb_pkg.sv
// prwb_pkg: shared types, widths, opcodes and helpers for the perfect reflector
// white balance block. No dependencies.
package prwb_pkg;

   localparam int HIST_BINS      = 767;
   localparam int HIST_AW        = 10;
   localparam int TOP_BIN        = HIST_BINS - 1;
   localparam int DEF_MAX_PIXELS = 4194304;
   localparam int PCT_W          = 7;
   localparam logic [PCT_W-1:0] PCT_RESET = 7'd10;
   localparam int CH_W           = 8;
   localparam int SUM_W          = 30;
   localparam int Q_W            = 16;
   localparam int LUT_DEPTH      = 256;
   localparam int LUT_AW         = 8;
   localparam int NUM_CH         = 3;

   localparam logic [1:0] OP_HIST    = 2'd0;
   localparam logic [1:0] OP_BRIGHT  = 2'd1;
   localparam logic [1:0] OP_CORRECT = 2'd2;

   typedef struct packed {
      logic [1:0]      opcode;
      logic [CH_W-1:0] blue_in;
      logic [CH_W-1:0] green_in;
      logic [CH_W-1:0] red_in;
      logic            last_of_pass;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0] blue_out;
      logic [CH_W-1:0] green_out;
      logic [CH_W-1:0] red_out;
      logic            frame_done;
   } rsp_type;

   typedef struct packed {
      logic               bump;
      logic [HIST_AW-1:0] bin;
      logic               walk;
   } hist_ctl_type;

   typedef struct packed {
      logic               busy;
      logic               thr_valid;
      logic [HIST_AW-1:0] threshold;
   } hist_stat_type;

   typedef struct packed {
      logic              en;
      logic [LUT_AW-1:0] addr;
      logic [CH_W-1:0]   blue;
      logic [CH_W-1:0]   green;
      logic [CH_W-1:0]   red;
   } fill_type;

   function automatic logic [CH_W-1:0] clamp_byte(input logic [31:0] v);
      return (|v[31:CH_W]) ? {CH_W{1'b1}} : v[CH_W-1:0];
   endfunction

endpackage

### hdl/prwb_stream_if.sv
// prwb_stream_if: valid/ready channel carrying one payload item.
// Payload type is given by the instantiating module; no other dependencies.
interface prwb_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hdl/prwb_ram.sv
// prwb_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
module prwb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### hdl/prwb_div.sv
// prwb_div: restoring serial divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module prwb_div #(
   parameter int NUM_W = 30,
   parameter int DEN_W = 23
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [NUM_W-1:0] quotient,
   output logic [DEN_W-1:0] remainder
);
   localparam int STEP_W = $clog2(NUM_W + 1);

   logic              busy_ff, busy_in, done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0]  rem_ff, rem_in, den_ff, den_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W:0]    trial, diff;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      ge      = trial >= {1'b0, den_ff};
      diff    = trial - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = STEP_W'(NUM_W);
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

### hdl/prwb_hist.sv
// prwb_hist: channel-sum histogram in RAM with read-modify-write bumps,
// reset clearing sweep and the threshold walk. Uses prwb_pkg and prwb_ram.
module prwb_hist #(
   parameter int MAX_PIXELS = prwb_pkg::DEF_MAX_PIXELS,
   localparam int CNT_W     = $clog2(MAX_PIXELS + 1),
   localparam int LIM_W     = CNT_W + prwb_pkg::PCT_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  prwb_pkg::hist_ctl_type  ctl,
   input  logic [LIM_W-1:0]        limit,
   output prwb_pkg::hist_stat_type stat
);
   localparam int AW    = prwb_pkg::HIST_AW;
   localparam int RUN_W = CNT_W + AW;
   localparam int MUL_W = RUN_W + 7;
   localparam logic [1:0] M_CLR  = 2'd0;
   localparam logic [1:0] M_IDLE = 2'd1;
   localparam logic [1:0] M_WALK = 2'd2;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PIXELS);

   logic [1:0]       mode_ff, mode_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic             iss_ff, iss_in;
   logic             b_valid_ff;
   logic [AW-1:0]    b_bin_ff;
   logic             r_valid_ff, r_valid_in;
   logic [AW-1:0]    r_idx_ff;
   logic             c_valid_ff;
   logic [AW-1:0]    c_idx_ff;
   logic [RUN_W-1:0] run_ff, run_in;
   logic             found_ff, found_in;
   logic [AW-1:0]    thr_ff, thr_in;
   logic             done_ff, done_in;
   logic             f_valid_ff;
   logic [AW-1:0]    f_bin_ff;
   logic [CNT_W-1:0] f_data_ff;

   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [CNT_W-1:0] wr_data, rd_data, old, bumped;
   logic [MUL_W-1:0] prod;

   prwb_ram #(.WIDTH(CNT_W), .DEPTH(prwb_pkg::HIST_BINS)) u_bins (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (1'b1),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rd_addr = (mode_ff == M_WALK) ? idx_ff : ctl.bin;
      // the RAM read misses a write made in the same cycle: forward it
      old     = (f_valid_ff && f_bin_ff == b_bin_ff) ? f_data_ff : rd_data;
      bumped  = (old >= CNT_MAX) ? CNT_MAX : old + 1'b1;
      wr_en   = 1'b0;
      wr_addr = b_bin_ff;
      wr_data = bumped;
      if (mode_ff == M_CLR) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff;
         wr_data = '0;
      end else if (r_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = r_idx_ff;
         wr_data = '0;
      end else if (b_valid_ff) begin
         wr_en = 1'b1;
      end

      prod = (MUL_W'(run_ff) << 6) + (MUL_W'(run_ff) << 5) + (MUL_W'(run_ff) << 2);

      mode_in    = mode_ff;
      idx_in     = idx_ff;
      iss_in     = iss_ff;
      r_valid_in = 1'b0;
      run_in     = r_valid_ff ? run_ff + RUN_W'(rd_data) : run_ff;
      found_in   = found_ff;
      thr_in     = thr_ff;
      done_in    = 1'b0;

      unique case (mode_ff)
         M_CLR: begin
            idx_in = idx_ff - 1'b1;
            if (idx_ff == '0) begin
               mode_in = M_IDLE;
            end
         end
         M_WALK: begin
            if (iss_ff) begin
               r_valid_in = 1'b1;
               idx_in     = idx_ff - 1'b1;
               if (idx_ff == '0) begin
                  iss_in = 1'b0;
               end
            end
            if (c_valid_ff && !found_ff && prod > MUL_W'(limit)) begin
               found_in = 1'b1;
               thr_in   = c_idx_ff;
            end
            if (c_valid_ff && c_idx_ff == '0) begin
               mode_in = M_IDLE;
               done_in = 1'b1;
            end
         end
         default: begin
            if (ctl.walk) begin
               mode_in  = M_WALK;
               idx_in   = AW'(prwb_pkg::TOP_BIN);
               iss_in   = 1'b1;
               run_in   = '0;
               found_in = 1'b0;
               thr_in   = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= M_CLR;
         idx_ff     <= AW'(prwb_pkg::TOP_BIN);
         iss_ff     <= 1'b0;
         b_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         found_ff   <= 1'b0;
         done_ff    <= 1'b0;
         f_valid_ff <= 1'b0;
         thr_ff     <= '0;
      end else begin
         mode_ff    <= mode_in;
         idx_ff     <= idx_in;
         iss_ff     <= iss_in;
         b_valid_ff <= ctl.bump;
         r_valid_ff <= r_valid_in;
         c_valid_ff <= r_valid_ff;
         found_ff   <= found_in;
         done_ff    <= done_in;
         f_valid_ff <= wr_en;
         thr_ff     <= thr_in;
      end
      b_bin_ff  <= ctl.bin;
      r_idx_ff  <= idx_ff;
      c_idx_ff  <= r_idx_ff;
      run_ff    <= run_in;
      f_bin_ff  <= wr_addr;
      f_data_ff <= wr_data;
   end

   assign stat.busy      = (mode_ff != M_IDLE);
   assign stat.thr_valid = done_ff;
   assign stat.threshold = thr_ff;
endmodule

### hdl/prwb_corr.sv
// prwb_corr: per-channel correction lookup RAMs and the correction-pass
// read pipeline with its result register. Uses prwb_pkg, prwb_ram, prwb_stream_if.
module prwb_corr (
   input  logic               clock,
   input  logic               reset,
   input  prwb_pkg::fill_type fill,
   input  logic               take,
   input  prwb_pkg::req_type  pix,
   output logic               can_take,
   prwb_stream_if.source      rsp_if
);
   localparam int CW = prwb_pkg::CH_W;

   logic [prwb_pkg::LUT_AW-1:0] lut_raddr [prwb_pkg::NUM_CH];
   logic [CW-1:0]               lut_wdata [prwb_pkg::NUM_CH];
   logic [CW-1:0]               lut_rdata [prwb_pkg::NUM_CH];

   logic              p_valid_ff, p_valid_in, p_last_ff;
   logic              out_valid_ff, out_valid_in;
   prwb_pkg::rsp_type out_data_ff, out_data_in;
   logic              adv;

   assign lut_raddr[0] = pix.blue_in;
   assign lut_raddr[1] = pix.green_in;
   assign lut_raddr[2] = pix.red_in;
   assign lut_wdata[0] = fill.blue;
   assign lut_wdata[1] = fill.green;
   assign lut_wdata[2] = fill.red;

   for (genvar g = 0; g < prwb_pkg::NUM_CH; g++) begin : g_lut
      prwb_ram #(.WIDTH(CW), .DEPTH(prwb_pkg::LUT_DEPTH)) u_lut (
         .clock   (clock),
         .wr_en   (fill.en),
         .wr_addr (fill.addr),
         .wr_data (lut_wdata[g]),
         .rd_en   (take),
         .rd_addr (lut_raddr[g]),
         .rd_data (lut_rdata[g])
      );
   end

   // RAM output holds while the item waits, since no new read is issued
   always_comb begin
      adv          = p_valid_ff && (!out_valid_ff || rsp_if.ready);
      can_take     = !p_valid_ff || adv;
      p_valid_in   = take ? 1'b1 : (adv ? 1'b0 : p_valid_ff);
      out_valid_in = out_valid_ff && !rsp_if.ready;
      out_data_in  = out_data_ff;
      if (adv) begin
         out_valid_in           = 1'b1;
         out_data_in.blue_out   = lut_rdata[0];
         out_data_in.green_out  = lut_rdata[1];
         out_data_in.red_out    = lut_rdata[2];
         out_data_in.frame_done = p_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         p_valid_ff   <= p_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (take) begin
         p_last_ff <= pix.last_of_pass;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_data_ff;
endmodule

### hdl/perfect_reflector_white_balance_core.sv
// perfect_reflector_white_balance_core: top level, pass control, accumulators,
// averages and correction lookup rebuild. Uses prwb_pkg, prwb_stream_if,
// prwb_hist, prwb_div and prwb_corr.
//
//   port       dir  kind           carries
//   req_if     in   valid/ready    opcode, blue/green/red_in, last_of_pass
//   rsp_if     out  valid/ready    blue/green/red_out, frame_done
//   csr_wr_*   in   write strobe   bright_percent
//
// Each pass takes one pixel per cycle while the block is idle and, in pass 2, while rsp_if takes results.
// End of pass 0: threshold walk over the histogram RAM.
// End of pass 1: three serial divides.
// First pass 2 pixel after a pass 0 pixel, a pass 1 end or a pass 2 end: lookup rebuild
// of three divides plus a 256-entry fill.
// After reset a clearing sweep of the histogram holds req_if.ready low.
module perfect_reflector_white_balance_core #(
   parameter int MAX_PIXELS = prwb_pkg::DEF_MAX_PIXELS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [prwb_pkg::PCT_W-1:0]  csr_wr_data,
   prwb_stream_if.sink                 req_if,
   prwb_stream_if.source               rsp_if
);
   localparam int CNT_W = $clog2(MAX_PIXELS + 1);
   localparam int LIM_W = CNT_W + prwb_pkg::PCT_W;
   localparam int CW    = prwb_pkg::CH_W;
   localparam int SW    = prwb_pkg::SUM_W;
   localparam int QW    = prwb_pkg::Q_W;
   localparam int DEN_W = (CNT_W > CW) ? CNT_W : CW;
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_PIXELS);
   localparam logic [1:0]       LAST_CH  = 2'(prwb_pkg::NUM_CH - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DRAIN = 3'd1;
   localparam logic [2:0] S_WALK  = 3'd2;
   localparam logic [2:0] S_AVG   = 3'd3;
   localparam logic [2:0] S_RECIP = 3'd4;
   localparam logic [2:0] S_FILL  = 3'd5;

   logic [2:0]                 state_ff, state_in;
   logic [prwb_pkg::PCT_W-1:0] pct_ff;
   logic [CW-1:0]              max_ff, max_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [prwb_pkg::HIST_AW-1:0] thr_ff, thr_in;
   logic [LIM_W-1:0]           limit_ff, limit_in;
   logic [SW-1:0]              bsum_ff [prwb_pkg::NUM_CH];
   logic [SW-1:0]              bsum_in [prwb_pkg::NUM_CH];
   logic [CNT_W-1:0]           bcnt_ff, bcnt_in;
   logic [CW-1:0]              avg_ff [prwb_pkg::NUM_CH];
   logic [CW-1:0]              avg_in [prwb_pkg::NUM_CH];
   logic [CW-1:0]              qstep_ff [prwb_pkg::NUM_CH];
   logic [CW-1:0]              qstep_in [prwb_pkg::NUM_CH];
   logic [CW-1:0]              rstep_ff [prwb_pkg::NUM_CH];
   logic [CW-1:0]              rstep_in [prwb_pkg::NUM_CH];
   logic [QW-1:0]              q_ff [prwb_pkg::NUM_CH];
   logic [QW-1:0]              q_in [prwb_pkg::NUM_CH];
   logic [CW-1:0]              r_ff [prwb_pkg::NUM_CH];
   logic [CW-1:0]              r_in [prwb_pkg::NUM_CH];
   logic [CW-1:0]              fval [prwb_pkg::NUM_CH];
   logic [CW:0]                rsum [prwb_pkg::NUM_CH];
   logic [CW-1:0]              chan [prwb_pkg::NUM_CH];
   logic [prwb_pkg::LUT_AW-1:0] c_ff, c_in;
   logic [1:0]                 k_ff, k_in;
   logic                       dirty_ff, dirty_in;
   logic                       divrun_ff, divrun_in;

   prwb_pkg::req_type       pix;
   prwb_pkg::hist_ctl_type  hist_ctl;
   prwb_pkg::hist_stat_type hist_stat;
   prwb_pkg::fill_type      fill;
   logic                    accept, take, corr_can_take;
   logic [prwb_pkg::HIST_AW-1:0] pix_sum;
   logic [SW:0]             addsum;
   logic                    div_start, div_busy, div_done, zero_den, step;
   logic [SW-1:0]           div_num, div_quo;
   logic [DEN_W-1:0]        div_den, div_rem;

   assign pix     = req_if.payload;
   assign chan[0] = pix.blue_in;
   assign chan[1] = pix.green_in;
   assign chan[2] = pix.red_in;
   assign pix_sum = prwb_pkg::HIST_AW'(pix.blue_in) + prwb_pkg::HIST_AW'(pix.green_in)
                  + prwb_pkg::HIST_AW'(pix.red_in);

   assign req_if.ready = (state_ff == S_IDLE) && !hist_stat.busy
                      && (pix.opcode != prwb_pkg::OP_CORRECT || (!dirty_ff && corr_can_take));
   assign accept = req_if.valid && req_if.ready;
   assign take   = accept && pix.opcode == prwb_pkg::OP_CORRECT;

   prwb_hist #(.MAX_PIXELS(MAX_PIXELS)) u_hist (
      .clock (clock),
      .reset (reset),
      .ctl   (hist_ctl),
      .limit (limit_ff),
      .stat  (hist_stat)
   );

   prwb_div #(.NUM_W(SW), .DEN_W(DEN_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_num),
      .divisor   (div_den),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   prwb_corr u_corr (
      .clock    (clock),
      .reset    (reset),
      .fill     (fill),
      .take     (take),
      .pix      (pix),
      .can_take (corr_can_take),
      .rsp_if   (rsp_if)
   );

   // shared divider: bright sums over bright count, then max over each average
   always_comb begin
      if (state_ff == S_AVG) begin
         div_num  = bsum_ff[k_ff];
         div_den  = DEN_W'(bcnt_ff);
         zero_den = (bcnt_ff == '0);
      end else begin
         div_num  = SW'(max_ff);
         div_den  = DEN_W'(avg_ff[k_ff]);
         zero_den = (avg_ff[k_ff] == '0);
      end
      div_start = (state_ff == S_AVG || state_ff == S_RECIP) && !divrun_ff && !zero_den;
   end

   always_comb begin
      state_in  = state_ff;
      max_in    = max_ff;
      count_in  = count_ff;
      thr_in    = thr_ff;
      limit_in  = limit_ff;
      bcnt_in   = bcnt_ff;
      c_in      = c_ff;
      k_in      = k_ff;
      dirty_in  = dirty_ff;
      divrun_in = divrun_ff;
      step      = 1'b0;
      addsum    = '0;
      hist_ctl.bump = 1'b0;
      hist_ctl.bin  = pix_sum;
      hist_ctl.walk = 1'b0;
      fill.en    = 1'b0;
      fill.addr  = c_ff;
      for (int i = 0; i < prwb_pkg::NUM_CH; i++) begin
         bsum_in[i]  = bsum_ff[i];
         avg_in[i]   = avg_ff[i];
         qstep_in[i] = qstep_ff[i];
         rstep_in[i] = rstep_ff[i];
         q_in[i]     = q_ff[i];
         r_in[i]     = r_ff[i];
         fval[i]     = (avg_ff[i] == '0) ? ((c_ff != '0) ? {CW{1'b1}} : '0)
                                         : prwb_pkg::clamp_byte(32'(q_ff[i]));
         rsum[i]     = (CW+1)'(r_ff[i]) + (CW+1)'(rstep_ff[i]);
      end
      fill.blue  = fval[0];
      fill.green = fval[1];
      fill.red   = fval[2];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (pix.opcode)
                  prwb_pkg::OP_HIST: begin
                     for (int i = 0; i < prwb_pkg::NUM_CH; i++) begin
                        if (chan[i] > max_in) begin
                           max_in = chan[i];
                        end
                     end
                     count_in      = (count_ff >= CNT_MAX) ? CNT_MAX : count_ff + 1'b1;
                     hist_ctl.bump = 1'b1;
                     dirty_in      = 1'b1;
                     if (pix.last_of_pass) begin
                        state_in = S_DRAIN;
                     end
                  end
                  prwb_pkg::OP_BRIGHT: begin
                     if (pix_sum > thr_ff) begin
                        for (int i = 0; i < prwb_pkg::NUM_CH; i++) begin
                           addsum     = {1'b0, bsum_ff[i]} + (SW+1)'(chan[i]);
                           bsum_in[i] = addsum[SW] ? {SW{1'b1}} : addsum[SW-1:0];
                        end
                        bcnt_in = (bcnt_ff >= CNT_MAX) ? CNT_MAX : bcnt_ff + 1'b1;
                     end
                     if (pix.last_of_pass) begin
                        state_in = S_AVG;
                        k_in     = '0;
                     end
                  end
                  prwb_pkg::OP_CORRECT: begin
                     if (pix.last_of_pass) begin
                        max_in   = '0;
                        dirty_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end else if (req_if.valid && pix.opcode == prwb_pkg::OP_CORRECT && dirty_ff
                         && !hist_stat.busy) begin
               state_in = S_RECIP;
               k_in     = '0;
            end
         end
         S_DRAIN: begin
            // last bump is written this cycle; the walk reads from the next one
            limit_in      = LIM_W'(pct_ff) * LIM_W'(count_ff);
            hist_ctl.walk = 1'b1;
            state_in      = S_WALK;
         end
         S_WALK: begin
            if (hist_stat.thr_valid) begin
               thr_in   = hist_stat.threshold;
               count_in = '0;
               state_in = S_IDLE;
            end
         end
         S_AVG, S_RECIP: begin
            if (!divrun_ff && zero_den) begin
               step = 1'b1;
               if (state_ff == S_AVG) begin
                  avg_in[k_ff] = '0;
               end else begin
                  qstep_in[k_ff] = '0;
                  rstep_in[k_ff] = '0;
               end
            end else if (!divrun_ff) begin
               divrun_in = 1'b1;
            end else if (div_done) begin
               divrun_in = 1'b0;
               step      = 1'b1;
               if (state_ff == S_AVG) begin
                  avg_in[k_ff] = prwb_pkg::clamp_byte(32'(div_quo));
               end else begin
                  qstep_in[k_ff] = div_quo[CW-1:0];
                  rstep_in[k_ff] = div_rem[CW-1:0];
               end
            end
            if (step) begin
               k_in = k_ff + 1'b1;
               if (k_ff == LAST_CH) begin
                  k_in = '0;
                  if (state_ff == S_AVG) begin
                     for (int i = 0; i < prwb_pkg::NUM_CH; i++) begin
                        bsum_in[i] = '0;
                     end
                     bcnt_in  = '0;
                     dirty_in = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     for (int i = 0; i < prwb_pkg::NUM_CH; i++) begin
                        q_in[i] = '0;
                        r_in[i] = '0;
                     end
                     c_in     = '0;
                     state_in = S_FILL;
                  end
               end
            end
         end
         S_FILL: begin
            // entry c holds c*max/avg clamped to 255; step by max/avg and carry the remainder
            fill.en = 1'b1;
            c_in    = c_ff + 1'b1;
            for (int i = 0; i < prwb_pkg::NUM_CH; i++) begin
               if (rsum[i] >= (CW+1)'(avg_ff[i])) begin
                  r_in[i] = CW'(rsum[i] - (CW+1)'(avg_ff[i]));
                  q_in[i] = q_ff[i] + QW'(qstep_ff[i]) + 1'b1;
               end else begin
                  r_in[i] = rsum[i][CW-1:0];
                  q_in[i] = q_ff[i] + QW'(qstep_ff[i]);
               end
            end
            if (c_ff == {prwb_pkg::LUT_AW{1'b1}}) begin
               dirty_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pct_ff    <= prwb_pkg::PCT_RESET;
         max_ff    <= '0;
         count_ff  <= '0;
         thr_ff    <= '0;
         bcnt_ff   <= '0;
         k_ff      <= '0;
         dirty_ff  <= 1'b1;
         divrun_ff <= 1'b0;
         for (int i = 0; i < prwb_pkg::NUM_CH; i++) begin
            bsum_ff[i] <= '0;
            avg_ff[i]  <= '0;
         end
      end else begin
         state_ff  <= state_in;
         pct_ff    <= csr_wr_en ? csr_wr_data : pct_ff;
         max_ff    <= max_in;
         count_ff  <= count_in;
         thr_ff    <= thr_in;
         bcnt_ff   <= bcnt_in;
         k_ff      <= k_in;
         dirty_ff  <= dirty_in;
         divrun_ff <= divrun_in;
         for (int i = 0; i < prwb_pkg::NUM_CH; i++) begin
            bsum_ff[i] <= bsum_in[i];
            avg_ff[i]  <= avg_in[i];
         end
      end
      limit_ff <= limit_in;
      c_ff     <= c_in;
      for (int i = 0; i < prwb_pkg::NUM_CH; i++) begin
         qstep_ff[i] <= qstep_in[i];
         rstep_ff[i] <= rstep_in[i];
         q_ff[i]     <= q_in[i];
         r_ff[i]     <= r_in[i];
      end
   end

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> (state_ff == S_IDLE && !hist_stat.busy))
      else $error("item accepted outside idle");

   a_lut_fresh: assert property (@(posedge clock) disable iff (reset)
      take |-> !dirty_ff)
      else $error("correction item read a stale lookup");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

   a_walk_after_drain: assert property (@(posedge clock) disable iff (reset)
      hist_ctl.walk |-> $past(hist_ctl.bump) || $past(state_ff) == S_IDLE)
      else $error("walk started without a closing pass 0 item");
endmodule
